// ----- hw/rtl/pcm_pkg.sv -----
package pcm_pkg;

  localparam int TABLE_INDEX_BITS = 8;
  localparam int FRACTION_BITS = 16;

  localparam int IN_W = 17;
  localparam int OUT_W = 24;
  localparam int EXPONENT_W = 16;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ONE_Q16 = 65536;
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRY = 1'b1;

  localparam int SEGS = 1 << TABLE_INDEX_BITS;
  localparam int SEG_W = TABLE_INDEX_BITS + 1;
  localparam int TAB_W = FRACTION_BITS + 2;
  localparam int R_W = 16 - TABLE_INDEX_BITS;
  localparam int LEAD_W = $clog2(IN_W);
  localparam int EXPO_W = 6;
  localparam int LG_W = FRACTION_BITS + EXPO_W;
  localparam int KM_W = FRACTION_BITS + 2;
  localparam int PROD_W = LG_W + KM_W;
  localparam int EI_W = PROD_W - FRACTION_BITS;
  localparam int SH_W = EI_W + 1;
  localparam int SHAMT_W = $clog2(FRACTION_BITS + 9);
  localparam int POW_CAP_LOG = 25;
  localparam int POW_W = POW_CAP_LOG + 1;
  localparam int POW_SH_W = $clog2(POW_CAP_LOG + 1);
  localparam int WIDE_W = TAB_W + POW_CAP_LOG;
  localparam int RES_W = POW_W + 2;

  typedef enum logic [MODE_W-1:0] {
    SYM_NONE  = 2'd0,
    SYM_POINT = 2'd1,
    SYM_AXIS  = 2'd2
  } sym_mode_e;

  typedef logic [TAB_W-1:0] tab_t [SEGS+1];

  typedef struct packed {
    logic point;
    logic neg;
    logic zero;
  } pcm_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    n = n_in;
    res = '0;
    bt = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt > n) begin
        bt = bt >> 2;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (bt != 64'd0) begin
        if (n >= res + bt) begin
          n = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Entry i holds log2(1 + i/SEGS), found bit by bit through repeated squaring.
  function automatic tab_t build_log_tab();
    tab_t t;
    logic [63:0] y;
    logic [31:0] lg;
    for (int i = 0; i < SEGS; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - TABLE_INDEX_BITS));
      lg = '0;
      for (int b = 0; b < FRACTION_BITS; b++) begin
        y = (y * y) >> 30;
        lg = lg << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          lg[0] = 1'b1;
        end
      end
      t[i] = TAB_W'(lg);
    end
    t[SEGS] = TAB_W'(64'd1 << FRACTION_BITS);
    return t;
  endfunction

  // Entry i holds 2^(i/SEGS), a product of repeated square roots of two.
  function automatic tab_t build_exp_tab();
    tab_t t;
    logic [63:0] root [TABLE_INDEX_BITS+1];
    logic [63:0] acc;
    root[0] = 64'd2 << 30;
    for (int j = 1; j <= TABLE_INDEX_BITS; j++) begin
      root[j] = isqrt64(root[j-1] << 30);
    end
    for (int i = 0; i < SEGS; i++) begin
      acc = 64'd1 << 30;
      for (int b = 0; b < TABLE_INDEX_BITS; b++) begin
        if (((i >> b) & 1) != 0) begin
          acc = (acc * root[TABLE_INDEX_BITS-b]) >> 30;
        end
      end
      t[i] = TAB_W'(acc >> (30 - FRACTION_BITS));
    end
    t[SEGS] = TAB_W'(64'd2 << FRACTION_BITS);
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

  function automatic logic [TAB_W-1:0] seg_lerp(input logic [TAB_W-1:0] lo,
                                                input logic [TAB_W-1:0] hi,
                                                input logic [R_W-1:0] r);
    logic [TAB_W-1:0] diff;
    logic [TAB_W+R_W-1:0] prod;
    diff = hi - lo;
    prod = {{R_W{1'b0}}, diff} * {{TAB_W{1'b0}}, r};
    return lo + prod[TAB_W+R_W-1:R_W];
  endfunction

  function automatic logic [TAB_W-1:0] log2_frac(input logic [15:0] f);
    logic [SEG_W-1:0] idx;
    logic [SEG_W-1:0] nxt;
    idx = {1'b0, f[15:R_W]};
    nxt = idx + SEG_W'(1);
    return seg_lerp(LOG_TAB[idx], LOG_TAB[nxt], f[R_W-1:0]);
  endfunction

  function automatic logic [TAB_W-1:0] exp2_frac(input logic [15:0] f);
    logic [SEG_W-1:0] idx;
    logic [SEG_W-1:0] nxt;
    idx = {1'b0, f[15:R_W]};
    nxt = idx + SEG_W'(1);
    return seg_lerp(EXP_TAB[idx], EXP_TAB[nxt], f[R_W-1:0]);
  endfunction

endpackage

// ----- hw/rtl/pcm_coef.sv -----
module pcm_coef import pcm_pkg::*; (
  input  logic                  clk_i,
  input  logic [EXPONENT_W-1:0] exponent_i,
  output logic [KM_W-1:0]       kmant_o,
  output logic [SHAMT_W-1:0]    shamt_o
);

  logic [KM_W-1:0]    kmant_d, kmant_q;
  logic [SHAMT_W-1:0] shamt_d, shamt_q;

  // The exponent is 2^int * 2^frac; the integer part becomes a shift of the product.
  always_comb begin
    kmant_d = KM_W'(exp2_frac({exponent_i[11:0], 4'b0000}));
    shamt_d = SHAMT_W'(FRACTION_BITS) - SHAMT_W'($signed(exponent_i[15:12]));
  end

  always_ff @(posedge clk_i) begin
    kmant_q <= kmant_d;
    shamt_q <= shamt_d;
  end

  assign kmant_o = kmant_q;
  assign shamt_o = shamt_q;

endmodule

// ----- hw/rtl/pcm_log.sv -----
module pcm_log import pcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic [IN_W-1:0]         x_i,
  input  logic [MODE_W-1:0]       mode_i,
  output logic                    valid_o,
  output logic signed [LG_W-1:0]  lg_o,
  output pcm_side_t               side_o
);

  localparam logic signed [EXPO_W-1:0] EXPO_WRAP = -6'sd31;

  logic signed [IN_W+1:0] centered;
  logic [IN_W:0]          mag;
  logic [IN_W:0]          base;
  logic [LEAD_W-1:0]      lead;
  logic                   found;
  logic                   sym;

  logic                     s1_valid_q;
  logic signed [EXPO_W-1:0] expo_d, expo_q;
  logic [15:0]              frac_d, frac_q;
  pcm_side_t                side1_d, side1_q;

  logic                   lg_valid_q;
  logic signed [LG_W-1:0] lg_d, lg_q;
  pcm_side_t              side2_q;

  always_comb begin
    centered = $signed({1'b0, x_i, 1'b0}) - (IN_W+2)'(ONE_Q16);
    mag = centered[IN_W+1] ? (IN_W+1)'(-centered) : centered[IN_W:0];
    sym = (mode_i == SYM_POINT) || (mode_i == SYM_AXIS);
    base = sym ? mag : {1'b0, x_i};
    lead = '0;
    found = 1'b0;
    for (int i = 0; i < IN_W; i++) begin
      if (base[i]) begin
        lead = LEAD_W'(i);
        found = 1'b1;
      end
    end
    frac_d = 16'(base[IN_W-1:0] << (LEAD_W'(IN_W - 1) - lead));
    // A base with only its top bit set makes the leading-one search wrap around.
    if (found) begin
      expo_d = $signed(EXPO_W'(lead) - EXPO_W'(IN_W - 1));
    end else if (base[IN_W]) begin
      expo_d = EXPO_WRAP;
    end else begin
      expo_d = '0;
    end
    side1_d.point = (mode_i == SYM_POINT);
    side1_d.neg = centered[IN_W+1];
    side1_d.zero = (base == '0);
  end

  always_comb begin
    lg_d = $signed({expo_q, {FRACTION_BITS{1'b0}}}) + $signed(LG_W'(log2_frac(frac_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lg_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      lg_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      expo_q <= expo_d;
      frac_q <= frac_d;
      side1_q <= side1_d;
      lg_q <= lg_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = lg_valid_q;
  assign lg_o = lg_q;
  assign side_o = side2_q;

endmodule

// ----- hw/rtl/pcm_exp.sv -----
module pcm_exp import pcm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic signed [LG_W-1:0] lg_i,
  input  pcm_side_t              side_i,
  input  logic [KM_W-1:0]        kmant_i,
  input  logic [SHAMT_W-1:0]     shamt_i,
  output logic                   valid_o,
  output logic [POW_W-1:0]       pow_o,
  output logic                   sat_o,
  output pcm_side_t              side_o
);

  localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(POW_CAP_LOG);
  localparam logic [WIDE_W-1:0] WIDE_CAP = WIDE_W'(1) << POW_CAP_LOG;
  localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << POW_CAP_LOG;

  logic signed [PROD_W-1:0] lg_x, km_x;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     s3_valid_q;
  pcm_side_t                side3_q;

  logic signed [PROD_W-1:0] ex;
  logic [EI_W-1:0]          ei;
  logic [15:0]              f16_d, f16_q;
  logic signed [SH_W-1:0]   sh_d, sh4_q;
  logic                     s4_valid_q;
  pcm_side_t                side4_q;

  logic [TAB_W-1:0]       m_q;
  logic signed [SH_W-1:0] sh5_q;
  logic                   s5_valid_q;
  pcm_side_t              side5_q;

  logic [WIDE_W-1:0] shl;
  logic [SH_W-1:0]   negsh;
  logic [POW_W-1:0]  pow_d, pow_q;
  logic              sat_d, sat_q;
  logic              s6_valid_q;
  pcm_side_t         side6_q;

  always_comb begin
    lg_x = PROD_W'(lg_i);
    km_x = $signed(PROD_W'(kmant_i));
    prod_d = lg_x * km_x;
  end

  always_comb begin
    ex = prod_q >>> shamt_i;
    ei = ex[PROD_W-1:FRACTION_BITS];
    f16_d = 16'({ex[FRACTION_BITS-1:0], 16'b0} >> FRACTION_BITS);
    sh_d = SH_W'($signed(ei)) + SH_W'(16 - FRACTION_BITS);
  end

  always_comb begin
    shl = WIDE_W'(m_q) << sh5_q[POW_SH_W-1:0];
    negsh = SH_W'(-sh5_q);
    pow_d = '0;
    sat_d = 1'b0;
    if (side5_q.zero) begin
      pow_d = '0;
    end else if (sh5_q > SH_MAX) begin
      pow_d = POW_CAP;
      sat_d = 1'b1;
    end else if (!sh5_q[SH_W-1]) begin
      if (shl >= WIDE_CAP) begin
        pow_d = POW_CAP;
        sat_d = 1'b1;
      end else begin
        pow_d = POW_W'(shl);
      end
    end else begin
      pow_d = POW_W'(m_q >> negsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      side3_q <= side_i;
      f16_q <= f16_d;
      sh4_q <= sh_d;
      side4_q <= side3_q;
      m_q <= exp2_frac(f16_q);
      sh5_q <= sh4_q;
      side5_q <= side4_q;
      pow_q <= pow_d;
      sat_q <= sat_d;
      side6_q <= side5_q;
    end
  end

  assign valid_o = s6_valid_q;
  assign pow_o = pow_q;
  assign sat_o = sat_q;
  assign side_o = side6_q;

endmodule

// ----- hw/rtl/power_curve_mapper.sv -----
// Throughput: one word per cycle while the output is not stalled, through seven register
// stages (two for the base logarithm, four for the product, shift, exp2 interpolation and
// power scaling, one for the output).
// A stalled output word holds the whole pipeline.
// Reset clears the stage valid bits and sets both configuration registers to zero.
module power_curve_mapper import pcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IN_W-1:0]         input_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] mapped_value_o,
  output logic                    saturated_o
);

  logic [EXPONENT_W-1:0] exponent_q;
  logic [MODE_W-1:0]     mode_q;

  logic                   adv;
  logic [KM_W-1:0]        kmant;
  logic [SHAMT_W-1:0]     shamt;
  logic                   lg_valid;
  logic signed [LG_W-1:0] lg;
  pcm_side_t              lg_side;
  logic                   pow_valid;
  logic [POW_W-1:0]       pow;
  logic                   pow_sat;
  pcm_side_t              pow_side;

  logic signed [RES_W-1:0] pw, sum, res;
  logic signed [OUT_W-1:0] mapped_d, mapped_q;
  logic                    sat_d, sat_q;
  logic                    out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= '0;
      mode_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXPONENT: exponent_q <= cfg_data_i[EXPONENT_W-1:0];
        CFG_SYMMETRY: mode_q <= cfg_data_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  pcm_coef u_coef (
    .clk_i      (clk_i),
    .exponent_i (exponent_q),
    .kmant_o    (kmant),
    .shamt_o    (shamt)
  );

  pcm_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .x_i     (input_value_i),
    .mode_i  (mode_q),
    .valid_o (lg_valid),
    .lg_o    (lg),
    .side_o  (lg_side)
  );

  pcm_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (lg_valid),
    .lg_i    (lg),
    .side_i  (lg_side),
    .kmant_i (kmant),
    .shamt_i (shamt),
    .valid_o (pow_valid),
    .pow_o   (pow),
    .sat_o   (pow_sat),
    .side_o  (pow_side)
  );

  // Point mode folds the power around one half: floor((1 +- power) / 2).
  always_comb begin
    pw = $signed(RES_W'(pow));
    sum = pow_side.neg ? (RES_W'(ONE_Q16) - pw) : (RES_W'(ONE_Q16) + pw);
    res = pow_side.point ? (sum >>> 1) : pw;
    sat_d = pow_sat;
    if (res > RES_W'(OUT_MAX)) begin
      mapped_d = OUT_W'(OUT_MAX);
      sat_d = 1'b1;
    end else if (res < RES_W'(OUT_MIN)) begin
      mapped_d = OUT_W'(OUT_MIN);
      sat_d = 1'b1;
    end else begin
      mapped_d = res[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pow_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mapped_q <= mapped_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mapped_value_o = mapped_q;
  assign saturated_o = sat_q;

endmodule

// ----- tb/power_curve_mapper_tb.sv -----
module power_curve_mapper_tb;
  import pcm_pkg::*;

  localparam logic [MODE_W-1:0] SYM_SPARE = 2'd3;

  localparam int SEG_BITS = 8;
  localparam int SEG_COUNT = 1 << SEG_BITS;
  localparam int FRAC_BITS = 16;
  localparam longint UNIT_Q16 = 65536;
  localparam longint POWER_CAP = 33554432;
  localparam longint WORD_MAX = 8388607;
  localparam longint WORD_MIN = -8388608;

  localparam int HOLDOFF_CYCLES = 60;
  localparam int PHASES = 16;
  localparam int PHASE_WORDS = 68;
  localparam int IDLE_TX [4] = '{0, 75, 0, 6};
  localparam int IDLE_RX [4] = '{0, 0, 75, 6};

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } curve_word_t;

  typedef struct packed {
    logic signed [15:0] p;
    logic [MODE_W-1:0]  mode;
    logic [IN_W-1:0]    x;
    logic               typed;
    logic [OUT_W-1:0]   value;
    logic               sat;
  } vector_t;

  localparam int N_DIRECTED = 24;
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{0,      SYM_NONE,  0,      1, 0,       0},
    '{0,      SYM_NONE,  65536,  1, 65536,   0},
    '{0,      SYM_NONE,  21845,  0, 0,       0},
    '{0,      SYM_NONE,  131071, 0, 0,       0},
    '{32767,  SYM_NONE,  131071, 1, 8388607, 1},
    '{32767,  SYM_NONE,  0,      1, 0,       0},
    '{32767,  SYM_NONE,  65535,  0, 0,       0},
    '{16384,  SYM_NONE,  131071, 1, 8388607, 1},
    '{12288,  SYM_NONE,  131071, 0, 0,       0},
    '{-32768, SYM_NONE,  1,      0, 0,       0},
    '{-32768, SYM_NONE,  0,      1, 0,       0},
    '{-32768, SYM_NONE,  65536,  1, 65536,   0},
    '{4096,   SYM_AXIS,  0,      1, 65536,   0},
    '{4096,   SYM_AXIS,  32768,  1, 0,       0},
    '{4096,   SYM_AXIS,  49152,  0, 0,       0},
    '{32767,  SYM_AXIS,  98303,  1, 8388607, 1},
    '{4096,   SYM_POINT, 32768,  1, 32768,   0},
    '{4096,   SYM_POINT, 0,      1, 0,       0},
    '{4096,   SYM_POINT, 65536,  1, 65536,   0},
    '{4096,   SYM_POINT, 16384,  0, 0,       0},
    '{32767,  SYM_POINT, 98303,  1, 8388607, 1},
    '{-12288, SYM_POINT, 40000,  0, 0,       0},
    '{4096,   SYM_SPARE, 65536,  1, 65536,   0},
    '{4096,   SYM_SPARE, 30000,  0, 0,       0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [IN_W-1:0]         input_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [OUT_W-1:0] mapped_value_o;
  logic                    saturated_o;

  longint log_curve [0:SEG_COUNT];
  longint exp_curve [0:SEG_COUNT];
  logic signed [15:0] curve_exp;
  logic [MODE_W-1:0] curve_sym;

  curve_word_t pending_words [$];
  logic word_typed;
  curve_word_t typed_word;
  int tx_idle_pct;
  int rx_stall_pct;
  int holdoff_tag;
  int mismatches;

  power_curve_mapper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .input_value_i (input_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mapped_value_o(mapped_value_o),
    .saturated_o   (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 30; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint curve_lerp(input bit pick_exp, input longint f16);
    int seg;
    longint w;
    longint lo;
    longint hi;
    seg = int'((f16 >> (16 - SEG_BITS)) & (SEG_COUNT - 1));
    w = f16 & ((1 << (16 - SEG_BITS)) - 1);
    lo = pick_exp ? exp_curve[seg] : log_curve[seg];
    hi = pick_exp ? exp_curve[seg + 1] : log_curve[seg + 1];
    return lo + (((hi - lo) * w) >>> (16 - SEG_BITS));
  endfunction

  function automatic longint raise_power(input longint v, output bit capped);
    int msb;
    int kexp;
    int ei;
    longint frac;
    longint lg;
    longint kmant;
    longint ex;
    longint m;
    longint pw;
    capped = 1'b0;
    if (v == 0) return 0;
    msb = 16;
    while (((v >> msb) & 1) == 0) msb--;
    frac = ((v << (31 - msb)) >> 15) & 16'hFFFF;
    lg = longint'(msb - 16) * UNIT_Q16 + curve_lerp(1'b0, frac);
    kexp = int'(curve_exp >>> 12);
    kmant = curve_lerp(1'b1, longint'({curve_exp[11:0], 4'b0000}));
    ex = (lg * kmant) >>> (FRAC_BITS - kexp);
    ei = int'(ex >>> FRAC_BITS);
    m = curve_lerp(1'b1, ex & 16'hFFFF);
    if (ei >= 0) begin
      if (ei > 25) begin
        capped = 1'b1;
        return POWER_CAP;
      end
      pw = m << ei;
      if (pw >= POWER_CAP) begin
        capped = 1'b1;
        return POWER_CAP;
      end
      return pw;
    end
    if (-ei >= 63) return 0;
    return m >> (-ei);
  endfunction

  function automatic curve_word_t map_word(input longint x);
    longint d;
    longint r;
    longint pw;
    bit cap;
    curve_word_t w;
    if (curve_sym == SYM_POINT || curve_sym == SYM_AXIS) begin
      d = 2 * x - UNIT_Q16;
      pw = raise_power((d < 0) ? -d : d, cap);
      if (curve_sym == SYM_AXIS) begin
        r = pw;
      end else begin
        r = ((d < 0) ? (UNIT_Q16 - pw) : (UNIT_Q16 + pw)) >>> 1;
      end
    end else begin
      r = raise_power(x, cap);
    end
    if (r > WORD_MAX) begin
      r = WORD_MAX;
      cap = 1'b1;
    end
    if (r < WORD_MIN) begin
      r = WORD_MIN;
      cap = 1'b1;
    end
    w.value = r[OUT_W-1:0];
    w.sat = cap;
    return w;
  endfunction

  function automatic logic [IN_W-1:0] draw_input(input logic [MODE_W-1:0] mode);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    if (pick < 12) return IN_W'(UNIT_Q16);
    if (pick < 16) return IN_W'(UNIT_Q16 / 2);
    if (pick < 24) begin
      if (mode == SYM_POINT || mode == SYM_AXIS) return IN_W'($urandom_range(65537, 98303));
      return IN_W'($urandom_range(65537, 131071));
    end
    return IN_W'($urandom_range(0, 65536));
  endfunction

  task automatic report_mismatch(input string what, input curve_word_t want,
                                 input curve_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected value %0d sat %0b, got value %0d sat %0b", $time, what,
               $signed(want.value), want.sat, $signed(got.value), got.sat);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic signed [15:0] p, input logic [MODE_W-1:0] mode);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_EXPONENT;
    cfg_data_i <= p;
    @(negedge clk_i);
    cfg_index_i <= CFG_SYMMETRY;
    cfg_data_i <= CFG_DATA_W'(mode);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    curve_exp = p;
    curve_sym = mode;
  endtask

  task automatic send_word(input logic [IN_W-1:0] x, input logic typed, input curve_word_t known);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    input_value_i <= x;
    word_typed = typed;
    typed_word = known;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : curve_tables
    longint unsigned roots [0:SEG_BITS];
    longint unsigned y;
    longint unsigned acc;
    longint lg;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= SEG_BITS; j++) roots[j] = int_sqrt(roots[j - 1] << 30);
    for (int i = 0; i < SEG_COUNT; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - SEG_BITS));
      lg = 0;
      for (int b = 0; b < FRAC_BITS; b++) begin
        y = (y * y) >> 30;
        lg = lg << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          lg = lg | 1;
        end
      end
      log_curve[i] = lg;
      acc = 64'd1 << 30;
      for (int b = 0; b < SEG_BITS; b++) begin
        if (((i >> b) & 1) != 0) acc = (acc * roots[SEG_BITS - b]) >> 30;
      end
      exp_curve[i] = longint'(acc >> (30 - FRAC_BITS));
    end
    log_curve[SEG_COUNT] = UNIT_Q16;
    exp_curve[SEG_COUNT] = 2 * UNIT_Q16;
  end

  initial begin : receiver
    int seen;
    int hold;
    seen = 0;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_tag != seen) begin
        seen = holdoff_tag;
        hold = HOLDOFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : port_check
    curve_word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_words.push_back(word_typed ? typed_word : map_word(longint'(input_value_i)));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("word with nothing pending", '0, {mapped_value_o, saturated_o});
        end else begin
          w = pending_words.pop_front();
          if ({mapped_value_o, saturated_o} !== w) begin
            report_mismatch("word mismatch", w, {mapped_value_o, saturated_o});
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("power_curve_mapper_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] p;
    logic [MODE_W-1:0] mode;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_EXPONENT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    input_value_i = '0;
    curve_exp = '0;
    curve_sym = SYM_NONE;
    word_typed = 1'b0;
    typed_word = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    holdoff_tag = 0;
    mismatches = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].p != curve_exp || DIRECTED[i].mode != curve_sym) begin
        wait_drain();
        apply_settings(DIRECTED[i].p, DIRECTED[i].mode);
      end
      send_word(DIRECTED[i].x, DIRECTED[i].typed, {DIRECTED[i].value, DIRECTED[i].sat});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      tx_idle_pct = IDLE_TX[ph % 4];
      rx_stall_pct <= IDLE_RX[ph % 4];
      if (ph == 0) p = 16'sh7FFF;
      else if (ph == 1) p = 16'sh8000;
      else if (ph == 2) p = '0;
      else if ($urandom_range(0, 1) == 1) p = 16'($urandom_range(0, 65535));
      else p = 16'(int'($urandom_range(0, 16384)) - 8192);
      mode = (ph == 2) ? SYM_AXIS : MODE_W'($urandom_range(0, 3));
      apply_settings(p, mode);
      if (ph == 4) holdoff_tag <= holdoff_tag + 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 5 && n == PHASE_WORDS / 2) wait_drain();
        send_word(draw_input(curve_sym), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (20) @(negedge clk_i);
    if (pending_words.size() != 0) begin
      mismatches += pending_words.size();
      $display("%0d words never arrived", pending_words.size());
    end
    if (mismatches == 0) begin
      $display("power_curve_mapper_tb OK");
    end else begin
      $display("power_curve_mapper_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- power_curve_mapper.f -----
hw/rtl/pcm_pkg.sv
hw/rtl/pcm_coef.sv
hw/rtl/pcm_log.sv
hw/rtl/pcm_exp.sv
hw/rtl/power_curve_mapper.sv
tb/power_curve_mapper_tb.sv
